// ----- sv/ssp_pkg.sv -----
`default_nettype none

package ssp_pkg;

  localparam logic [7:0] SyncByte    = 8'hFF;
  localparam logic [7:0] LenOverhead = 8'd2;

  // Parser phase codes. Unused codes behave like PhSync1.
  localparam logic [2:0] PhSync1 = 3'd0;
  localparam logic [2:0] PhSync2 = 3'd1;
  localparam logic [2:0] PhId    = 3'd2;
  localparam logic [2:0] PhLen   = 3'd3;
  localparam logic [2:0] PhErr   = 3'd4;
  localparam logic [2:0] PhParam = 3'd5;
  localparam logic [2:0] PhCsum  = 3'd6;

  typedef enum logic [2:0] {
    EvParam    = 3'd0,
    EvOk       = 3'd1,
    EvCsumBad  = 3'd2,
    EvSync1Bad = 3'd3,
    EvSync2Bad = 3'd4
  } event_kind_e;

endpackage

`default_nettype wire

// ----- sv/servo_status_packet_parser.sv -----
// Channel  Handshake              Payload
// rx       rx_valid_i/rx_ready_o  rx_byte_i
// ev       ev_valid_o/ev_ready_i  event_kind_o, servo_id_o, frame_length_o,
//                                 error_bits_o, param_index_o, param_byte_o,
//                                 frame_end_o
//
// One received word is accepted per cycle while rx_ready_o is high; its event,
// if any, appears in the output register on the next cycle.
// The single output register sets the rate: a new word is taken whenever that
// register is empty or is being drained in the same cycle.
// An asynchronous low reset returns the parser to hunting the first sync byte.
// A stall on the event side holds rx_ready_o low only while an event waits.
`default_nettype none

module servo_status_packet_parser
  import ssp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            ev_valid_o,
  input  wire logic       ev_ready_i,
  output logic [2:0]      event_kind_o,
  output logic [7:0]      servo_id_o,
  output logic [7:0]      frame_length_o,
  output logic [7:0]      error_bits_o,
  output logic [7:0]      param_index_o,
  output logic [7:0]      param_byte_o,
  output logic            frame_end_o
);

  logic [2:0] phase_q, phase_d;
  logic [7:0] held_id_q, held_id_d;
  logic [7:0] held_length_q, held_length_d;
  logic [7:0] held_error_q, held_error_d;
  logic [7:0] running_sum_q, running_sum_d;
  logic [7:0] params_left_q, params_left_d;

  logic        ev_valid_q, ev_valid_d;
  event_kind_e kind_q;
  logic [7:0]  id_q, len_q, err_q, idx_q, val_q;
  logic        end_q;

  logic        rx_fire;
  logic        emit;
  event_kind_e kind;
  logic        frame_info;
  logic [7:0]  idx;
  logic [7:0]  val;
  logic        frame_end;
  logic [7:0]  param_total;
  logic [7:0]  params_next;

  assign rx_ready_o = !ev_valid_q || ev_ready_i;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  assign param_total = (held_length_q > LenOverhead) ? held_length_q - LenOverhead : 8'd0;
  assign params_next = (params_left_q != 8'd0) ? params_left_q - 8'd1 : 8'd0;

  always_comb begin
    phase_d       = phase_q;
    held_id_d     = held_id_q;
    held_length_d = held_length_q;
    held_error_d  = held_error_q;
    running_sum_d = running_sum_q;
    params_left_d = params_left_q;
    emit          = 1'b0;
    kind          = EvParam;
    frame_info    = 1'b0;
    idx           = 8'd0;
    val           = 8'd0;
    frame_end     = 1'b0;
    unique case (phase_q)
      PhSync2: begin
        if (rx_byte_i == SyncByte) begin
          phase_d = PhId;
        end else begin
          phase_d   = PhSync1;
          emit      = 1'b1;
          kind      = EvSync2Bad;
          frame_end = 1'b1;
        end
      end
      PhId: begin
        held_id_d     = rx_byte_i;
        running_sum_d = rx_byte_i;
        phase_d       = PhLen;
      end
      PhLen: begin
        held_length_d = rx_byte_i;
        running_sum_d = running_sum_q + rx_byte_i;
        params_left_d = (rx_byte_i > LenOverhead) ? rx_byte_i - LenOverhead : 8'd0;
        phase_d       = PhErr;
      end
      PhErr: begin
        held_error_d  = rx_byte_i;
        running_sum_d = running_sum_q + rx_byte_i;
        phase_d       = (params_left_q != 8'd0) ? PhParam : PhCsum;
      end
      PhParam: begin
        running_sum_d = running_sum_q + rx_byte_i;
        params_left_d = params_next;
        if (params_next == 8'd0) begin
          phase_d = PhCsum;
        end
        emit       = 1'b1;
        kind       = EvParam;
        frame_info = 1'b1;
        idx        = param_total - params_left_q;
        val        = rx_byte_i;
      end
      PhCsum: begin
        phase_d    = PhSync1;
        emit       = 1'b1;
        kind       = (rx_byte_i == ~running_sum_q) ? EvOk : EvCsumBad;
        frame_info = 1'b1;
        frame_end  = 1'b1;
      end
      default: begin
        // First sync byte, and any phase code that has no meaning.
        if (rx_byte_i == SyncByte) begin
          phase_d = PhSync2;
        end else begin
          phase_d   = PhSync1;
          emit      = 1'b1;
          kind      = EvSync1Bad;
          frame_end = 1'b1;
        end
      end
    endcase
  end

  assign ev_valid_d = (rx_fire && emit) || (ev_valid_q && !ev_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhSync1;
      held_id_q     <= 8'd0;
      held_length_q <= 8'd0;
      held_error_q  <= 8'd0;
      running_sum_q <= 8'd0;
      params_left_q <= 8'd0;
      ev_valid_q    <= 1'b0;
    end else begin
      ev_valid_q <= ev_valid_d;
      if (rx_fire) begin
        phase_q       <= phase_d;
        held_id_q     <= held_id_d;
        held_length_q <= held_length_d;
        held_error_q  <= held_error_d;
        running_sum_q <= running_sum_d;
        params_left_q <= params_left_d;
      end
    end
  end

  // The frame fields come from the held values before this word updates them.
  always_ff @(posedge clk_i) begin
    if (rx_fire && emit) begin
      kind_q <= kind;
      id_q   <= frame_info ? held_id_q : 8'd0;
      len_q  <= frame_info ? held_length_q : 8'd0;
      err_q  <= frame_info ? held_error_q : 8'd0;
      idx_q  <= idx;
      val_q  <= val;
      end_q  <= frame_end;
    end
  end

  assign ev_valid_o     = ev_valid_q;
  assign event_kind_o   = kind_q;
  assign servo_id_o     = id_q;
  assign frame_length_o = len_q;
  assign error_bits_o   = err_q;
  assign param_index_o  = idx_q;
  assign param_byte_o   = val_q;
  assign frame_end_o    = end_q;

  a_param_phase_has_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhParam) |-> (params_left_q != 8'd0))
    else $error("parameter phase entered with no parameter words left");

  a_end_matches_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_o |-> (frame_end_o == (event_kind_o != EvParam)))
    else $error("frame_end disagrees with event kind");

  a_sync_err_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid_o && (event_kind_o == EvSync1Bad || event_kind_o == EvSync2Bad))
      |-> (servo_id_o == 8'd0 && frame_length_o == 8'd0 && error_bits_o == 8'd0))
    else $error("sync error event carries frame fields");

  a_error_returns_to_hunt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_fire && emit && frame_end) |=> (phase_q == PhSync1))
    else $error("parser did not return to hunting after a closing event");

endmodule

`default_nettype wire
